[rtl/assert_macros.svh]
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/ghs_pkg.sv]
// Shared constants, codes and interface types of the GHS node.
package ghs_pkg;

  localparam int MAX_EDGES_DEF   = 16;
  localparam int DEFER_DEPTH_DEF = 32;

  localparam logic [16:0] INF_W  = 17'd100000;
  localparam logic [6:0]  NIL_ID = 7'd127;
  localparam logic [3:0]  LVL_MAX = 4'd15;
  localparam logic [4:0]  RPT_MAX = 5'd31;

  localparam logic [3:0] M_LOAD   = 4'd0;
  localparam logic [3:0] M_WAKE   = 4'd1;
  localparam logic [3:0] M_CONN   = 4'd2;
  localparam logic [3:0] M_INIT   = 4'd3;
  localparam logic [3:0] M_TEST   = 4'd4;
  localparam logic [3:0] M_ACC    = 4'd5;
  localparam logic [3:0] M_REJ    = 4'd6;
  localparam logic [3:0] M_REP    = 4'd7;
  localparam logic [3:0] M_CHROOT = 4'd8;
  localparam logic [3:0] M_TERM   = 4'd9;
  localparam logic [3:0] M_POLL   = 4'd10;
  localparam logic [3:0] M_READ   = 4'd11;

  localparam logic [3:0] K_CONNECT  = 4'd0;
  localparam logic [3:0] K_INITIATE = 4'd1;
  localparam logic [3:0] K_TEST     = 4'd2;
  localparam logic [3:0] K_ACCEPT   = 4'd3;
  localparam logic [3:0] K_REJECT   = 4'd4;
  localparam logic [3:0] K_REPORT   = 4'd5;
  localparam logic [3:0] K_CHROOT   = 4'd6;
  localparam logic [3:0] K_TERM     = 4'd7;
  localparam logic [3:0] K_HALT     = 4'd8;
  localparam logic [3:0] K_READ     = 4'd9;

  localparam logic [1:0] CL_BASIC  = 2'd0;
  localparam logic [1:0] CL_BRANCH = 2'd1;
  localparam logic [1:0] CL_REJECT = 2'd2;

  localparam logic [1:0] PH_SLEEP = 2'd0;
  localparam logic [1:0] PH_FIND  = 2'd1;
  localparam logic [1:0] PH_FOUND = 2'd2;

  localparam logic [1:0] D_CONN = 2'd0;
  localparam logic [1:0] D_TEST = 2'd1;
  localparam logic [1:0] D_REP  = 2'd2;

  localparam logic [1:0] SC_FIND = 2'd0;
  localparam logic [1:0] SC_MIN  = 2'd1;
  localparam logic [1:0] SC_CNT  = 2'd2;
  localparam logic [1:0] SC_LIST = 2'd3;

  typedef struct packed {
    logic        start;
    logic [1:0]  op;
    logic [6:0]  key;
    logic        use_exc;
    logic        load_idx;
    logic        wr_class;
    logic        wr_min;
    logic [1:0]  wr_val;
    logic        load;
    logic [16:0] ld_w;
  } ghs_cmd_t;

  typedef struct packed {
    logic        done;
    logic        found;
    logic        min_found;
    logic [5:0]  min_id;
    logic        hit;
    logic [5:0]  hit_id;
    logic [6:0]  count;
    logic [5:0]  rd_id;
    logic [16:0] rd_w;
    logic [1:0]  rd_class;
  } ghs_sts_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [5:0]  dest;
    logic [3:0]  lvl;
    logic [16:0] val;
    logic        find;
    logic [1:0]  ek;
    logic        ev;
  } ghs_res_t;

  typedef struct packed {
    logic     en;
    ghs_res_t res;
  } ghs_emit_t;

  typedef struct packed {
    logic [1:0]  k;
    logic [5:0]  src;
    logic [3:0]  lvl;
    logic [16:0] val;
  } ghs_defer_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    ghs_defer_t ent;
  } ghs_fcmd_t;

endpackage

[rtl/ghs_etab.sv]
// Edge table with a one-entry-per-cycle scan unit.
module ghs_etab #(
  parameter int MAX_EDGES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ghs_pkg::ghs_cmd_t cmd,
  output ghs_pkg::ghs_sts_t sts
);
  import ghs_pkg::*;

  localparam int IW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int TW = $clog2(MAX_EDGES + 1);

  logic [5:0]    id_mem [MAX_EDGES];
  logic [16:0]   w_mem  [MAX_EDGES];
  logic [1:0]    cls_r  [MAX_EDGES];
  logic [TW-1:0] total_r, i_r;
  logic          busy_r, use_r, found_r, min_found_r;
  logic [1:0]    op_r;
  logic [6:0]    key_r, cnt_r;
  logic [IW-1:0] fidx_r, midx_r, raddr, waddr;
  logic [5:0]    min_id_r, e_id;
  logic [16:0]   min_w_r, e_w;
  logic [1:0]    e_cls;
  logic          in_range, load_ok;

  assign raddr    = busy_r ? i_r[IW-1:0] : fidx_r;
  assign waddr    = cmd.wr_min ? midx_r : fidx_r;
  assign e_id     = id_mem[raddr];
  assign e_w      = w_mem[raddr];
  assign e_cls    = cls_r[raddr];
  assign in_range = busy_r && (i_r < total_r);
  assign load_ok  = cmd.load && (cmd.ld_w != INF_W) && (total_r < TW'(MAX_EDGES));

  always_ff @(posedge clk) begin
    if (load_ok) begin
      id_mem[total_r[IW-1:0]] <= cmd.key[5:0];
      w_mem[total_r[IW-1:0]]  <= cmd.ld_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_EDGES; k++) begin
        cls_r[k] <= CL_BASIC;
      end
      total_r     <= '0;
      busy_r      <= 1'b0;
      found_r     <= 1'b0;
      min_found_r <= 1'b0;
      i_r         <= '0;
      op_r        <= SC_FIND;
      key_r       <= '0;
      use_r       <= 1'b0;
      fidx_r      <= '0;
      midx_r      <= '0;
      min_id_r    <= '0;
      min_w_r     <= '0;
      cnt_r       <= '0;
    end else begin
      if (load_ok) begin
        cls_r[total_r[IW-1:0]] <= CL_BASIC;
        total_r <= total_r + 1'b1;
      end
      if (cmd.wr_class) begin
        cls_r[waddr] <= cmd.wr_val;
      end
      if (cmd.load_idx) begin
        fidx_r  <= cmd.key[IW-1:0];
        found_r <= (32'(cmd.key) < 32'(total_r));
      end
      if (cmd.start) begin
        busy_r <= 1'b1;
        i_r    <= '0;
        op_r   <= cmd.op;
        key_r  <= cmd.key;
        use_r  <= cmd.use_exc;
        case (cmd.op)
          SC_FIND: found_r     <= 1'b0;
          SC_MIN:  min_found_r <= 1'b0;
          SC_CNT:  cnt_r       <= '0;
          default: ;
        endcase
      end else if (in_range) begin
        i_r <= i_r + 1'b1;
        case (op_r)
          SC_FIND: begin
            if (!found_r && ({1'b0, e_id} == key_r)) begin
              found_r <= 1'b1;
              fidx_r  <= i_r[IW-1:0];
            end
          end
          SC_MIN: begin
            if ((e_cls == CL_BASIC) && (!min_found_r || (e_w < min_w_r))) begin
              min_found_r <= 1'b1;
              midx_r      <= i_r[IW-1:0];
              min_id_r    <= e_id;
              min_w_r     <= e_w;
            end
          end
          SC_CNT: begin
            if ((e_cls == CL_BRANCH) && (e_id != key_r[5:0])) begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
          default: ;
        endcase
      end else if (busy_r) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts           = '0;
    sts.done      = busy_r && !in_range;
    sts.found     = found_r;
    sts.min_found = min_found_r;
    sts.min_id    = min_id_r;
    sts.hit       = in_range && (op_r == SC_LIST) && (e_cls == CL_BRANCH) &&
                    !(use_r && (e_id == key_r[5:0]));
    sts.hit_id    = e_id;
    sts.count     = cnt_r;
    sts.rd_id     = e_id;
    sts.rd_w      = e_w;
    sts.rd_class  = e_cls;
  end

endmodule

[rtl/ghs_dfifo.sv]
// FIFO of deferred protocol messages with a sticky overflow flag.
module ghs_dfifo #(
  parameter int DEFER_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ghs_pkg::ghs_fcmd_t  fcmd,
  output ghs_pkg::ghs_defer_t rd_ent,
  output logic                empty,
  output logic                ovf
);
  import ghs_pkg::*;

  localparam int PW = $clog2(DEFER_DEPTH);
  localparam int FW = $clog2(DEFER_DEPTH + 1);

  ghs_defer_t    mem [DEFER_DEPTH];
  ghs_defer_t    rd_r;
  logic [PW-1:0] head_r, tail_r;
  logic [FW-1:0] fill_r;
  logic          ovf_r, full;

  assign full   = (fill_r == FW'(DEFER_DEPTH));
  assign empty  = (fill_r == '0);
  assign ovf    = ovf_r;
  assign rd_ent = rd_r;

  always_ff @(posedge clk) begin
    if (fcmd.push && !full) begin
      mem[tail_r] <= fcmd.ent;
    end
    if (fcmd.pop) begin
      rd_r <= mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
      ovf_r  <= 1'b0;
    end else begin
      if (fcmd.push) begin
        if (full) begin
          ovf_r <= 1'b1;
        end else begin
          tail_r <= (tail_r == PW'(DEFER_DEPTH - 1)) ? '0 : tail_r + 1'b1;
          fill_r <= fill_r + 1'b1;
        end
      end else if (fcmd.pop && !empty) begin
        head_r <= (head_r == PW'(DEFER_DEPTH - 1)) ? '0 : head_r + 1'b1;
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

[rtl/ghs_obuf.sv]
// Result buffer that collects one item's words and drains them to the output register.
module ghs_obuf #(
  parameter int CAP = 34
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ghs_pkg::ghs_emit_t emit,
  input  logic               flush,
  input  logic               ovf,
  output logic               done,
  output logic               out_valid,
  input  logic               out_ready,
  output ghs_pkg::ghs_res_t  out_res,
  output logic               out_last,
  output logic               out_ovf
);
  import ghs_pkg::*;

  localparam int CW = $clog2(CAP + 1);
  localparam int AW = $clog2(CAP);

  ghs_res_t      mem [CAP];
  ghs_res_t      rd_r, out_res_r;
  logic [CW-1:0] cnt_r, idx_r;
  logic          drain_r, rd_ok_r, out_valid_r, out_last_r, out_ovf_r;
  logic          slot_free, do_load, do_read;

  assign slot_free = !out_valid_r || out_ready;
  assign done      = drain_r && (idx_r == cnt_r);
  assign do_read   = drain_r && !rd_ok_r && (idx_r < cnt_r);
  assign do_load   = rd_ok_r && slot_free;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_last  = out_last_r;
  assign out_ovf   = out_ovf_r;

  always_ff @(posedge clk) begin
    if (emit.en && (cnt_r < CW'(CAP))) begin
      mem[cnt_r[AW-1:0]] <= emit.res;
    end
    if (do_read) begin
      rd_r <= mem[idx_r[AW-1:0]];
    end
    if (do_load) begin
      out_res_r  <= rd_r;
      out_last_r <= ((idx_r + 1'b1) == cnt_r);
      out_ovf_r  <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      idx_r       <= '0;
      drain_r     <= 1'b0;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit.en && (cnt_r < CW'(CAP))) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (flush) begin
        drain_r <= 1'b1;
        idx_r   <= '0;
        rd_ok_r <= 1'b0;
      end else if (done) begin
        drain_r <= 1'b0;
        cnt_r   <= '0;
      end else if (do_read) begin
        rd_ok_r <= 1'b1;
      end else if (do_load) begin
        rd_ok_r <= 1'b0;
        idx_r   <= idx_r + 1'b1;
      end
      if (do_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

[rtl/ghs_ctrl.sv]
// Protocol controller: node state and the sequencer that drives the datapath.
module ghs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [3:0]          in_mode,
  input  logic [5:0]          in_src_node,
  input  logic [3:0]          in_level,
  input  logic [16:0]         in_value,
  input  logic                in_find,
  input  logic [3:0]          in_edge_index,
  output ghs_pkg::ghs_cmd_t   cmd,
  input  ghs_pkg::ghs_sts_t   sts,
  output ghs_pkg::ghs_fcmd_t  fcmd,
  input  ghs_pkg::ghs_defer_t rd_ent,
  input  logic                fifo_empty,
  output ghs_pkg::ghs_emit_t  emit,
  output logic                flush,
  input  logic                flush_done
);
  import ghs_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DISP   = 5'd1;
  localparam logic [4:0] S_GO     = 5'd2;
  localparam logic [4:0] S_CR0    = 5'd3;
  localparam logic [4:0] S_FIND_W = 5'd4;
  localparam logic [4:0] S_WAKE   = 5'd5;
  localparam logic [4:0] S_WAKE_W = 5'd6;
  localparam logic [4:0] S_CONN   = 5'd7;
  localparam logic [4:0] S_TEST   = 5'd8;
  localparam logic [4:0] S_ACC    = 5'd9;
  localparam logic [4:0] S_REJ    = 5'd10;
  localparam logic [4:0] S_DT     = 5'd11;
  localparam logic [4:0] S_DT_W   = 5'd12;
  localparam logic [4:0] S_DR     = 5'd13;
  localparam logic [4:0] S_DR_W   = 5'd14;
  localparam logic [4:0] S_REP    = 5'd15;
  localparam logic [4:0] S_LIST_W = 5'd16;
  localparam logic [4:0] S_CR     = 5'd17;
  localparam logic [4:0] S_READ   = 5'd18;
  localparam logic [4:0] S_END    = 5'd19;
  localparam logic [4:0] S_POP    = 5'd20;
  localparam logic [4:0] S_RDISP  = 5'd21;
  localparam logic [4:0] S_FLUSH  = 5'd22;
  localparam logic [4:0] S_FW     = 5'd23;

  logic [4:0]  state_r, state_nxt, after_wake;
  logic [3:0]  op_r, op_nxt, l_r, l_nxt, e_r, e_nxt;
  logic [5:0]  q_r, q_nxt, parent_r, parent_nxt;
  logic [16:0] v_r, v_nxt, name_r, name_nxt, best_w_r, best_w_nxt;
  logic        f_r, f_nxt, retry_r, retry_nxt, halted_r, halted_nxt;
  logic [3:0]  level_r, level_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [6:0]  best_id_r, best_id_nxt, probe_r, probe_nxt;
  logic [4:0]  reports_r, reports_nxt;

  assign after_wake = (op_r == M_CONN) ? S_CONN : (op_r == M_TEST) ? S_TEST : S_END;

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    q_nxt       = q_r;
    l_nxt       = l_r;
    v_nxt       = v_r;
    f_nxt       = f_r;
    e_nxt       = e_r;
    retry_nxt   = retry_r;
    level_nxt   = level_r;
    name_nxt    = name_r;
    phase_nxt   = phase_r;
    parent_nxt  = parent_r;
    best_id_nxt = best_id_r;
    best_w_nxt  = best_w_r;
    probe_nxt   = probe_r;
    reports_nxt = reports_r;
    halted_nxt  = halted_r;
    cmd         = '0;
    fcmd        = '0;
    emit        = '0;
    flush       = 1'b0;
    in_ready    = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_mode;
          q_nxt     = in_src_node;
          l_nxt     = in_level;
          v_nxt     = in_value;
          f_nxt     = in_find;
          e_nxt     = in_edge_index;
          retry_nxt = 1'b0;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (op_r == M_LOAD) begin
          cmd.load  = 1'b1;
          cmd.key   = {1'b0, q_r};
          cmd.ld_w  = v_r;
          state_nxt = S_IDLE;
        end else if (op_r == M_READ) begin
          cmd.load_idx = 1'b1;
          cmd.key      = {3'b000, e_r};
          state_nxt    = S_READ;
        end else begin
          state_nxt = halted_r ? S_END : S_GO;
        end
      end
      S_GO: begin
        case (op_r)
          M_WAKE: state_nxt = S_WAKE;
          M_CONN, M_TEST, M_ACC, M_REJ: begin
            cmd.start = 1'b1;
            cmd.op    = SC_FIND;
            cmd.key   = {1'b0, q_r};
            state_nxt = S_FIND_W;
          end
          M_INIT: begin
            level_nxt   = l_r;
            name_nxt    = v_r;
            phase_nxt   = f_r ? PH_FIND : PH_FOUND;
            parent_nxt  = q_r;
            best_id_nxt = NIL_ID;
            best_w_nxt  = INF_W;
            cmd.start   = 1'b1;
            cmd.op      = SC_LIST;
            cmd.key     = {1'b0, q_r};
            cmd.use_exc = 1'b1;
            state_nxt   = S_LIST_W;
          end
          M_REP:    state_nxt = S_REP;
          M_CHROOT: state_nxt = S_CR0;
          M_TERM: begin
            cmd.start   = 1'b1;
            cmd.op      = SC_LIST;
            cmd.key     = {1'b0, q_r};
            cmd.use_exc = 1'b1;
            state_nxt   = S_LIST_W;
          end
          default: state_nxt = S_END;
        endcase
      end
      S_CR0: begin
        if (best_id_r == NIL_ID) begin
          state_nxt = S_END;
        end else begin
          cmd.start = 1'b1;
          cmd.op    = SC_FIND;
          cmd.key   = best_id_r;
          state_nxt = S_FIND_W;
        end
      end
      S_FIND_W: begin
        if (sts.done) begin
          if (!sts.found) begin
            state_nxt = S_END;
          end else begin
            case (op_r)
              M_CONN, M_TEST: state_nxt = S_WAKE;
              M_ACC:          state_nxt = S_ACC;
              M_REJ:          state_nxt = S_REJ;
              M_CHROOT:       state_nxt = S_CR;
              default:        state_nxt = S_END;
            endcase
          end
        end
      end
      S_WAKE: begin
        if (phase_r != PH_SLEEP) begin
          state_nxt = after_wake;
        end else begin
          cmd.start = 1'b1;
          cmd.op    = SC_MIN;
          state_nxt = S_WAKE_W;
        end
      end
      S_WAKE_W: begin
        if (sts.done) begin
          if (sts.min_found) begin
            cmd.wr_class  = 1'b1;
            cmd.wr_min    = 1'b1;
            cmd.wr_val    = CL_BRANCH;
            level_nxt     = '0;
            phase_nxt     = PH_FOUND;
            reports_nxt   = '0;
            emit.en       = 1'b1;
            emit.res.kind = K_CONNECT;
            emit.res.dest = sts.min_id;
          end
          state_nxt = after_wake;
        end
      end
      S_CONN: begin
        if (l_r < level_r) begin
          cmd.wr_class  = 1'b1;
          cmd.wr_val    = CL_BRANCH;
          emit.en       = 1'b1;
          emit.res.kind = K_INITIATE;
          emit.res.dest = q_r;
          emit.res.lvl  = level_r;
          emit.res.val  = name_r;
          emit.res.find = (phase_r == PH_FIND);
        end else if (sts.rd_class == CL_BASIC) begin
          fcmd.push     = 1'b1;
          fcmd.ent.k    = D_CONN;
          fcmd.ent.src  = q_r;
          fcmd.ent.lvl  = l_r;
        end else begin
          emit.en       = 1'b1;
          emit.res.kind = K_INITIATE;
          emit.res.dest = q_r;
          emit.res.lvl  = (level_r < LVL_MAX) ? level_r + 1'b1 : LVL_MAX;
          emit.res.val  = sts.rd_w;
          emit.res.find = 1'b1;
        end
        state_nxt = S_END;
      end
      S_TEST: begin
        state_nxt = S_END;
        if (l_r > level_r) begin
          fcmd.push    = 1'b1;
          fcmd.ent.k   = D_TEST;
          fcmd.ent.src = q_r;
          fcmd.ent.lvl = l_r;
          fcmd.ent.val = v_r;
        end else if (v_r != name_r) begin
          emit.en       = 1'b1;
          emit.res.kind = K_ACCEPT;
          emit.res.dest = q_r;
        end else begin
          if (sts.rd_class == CL_BASIC) begin
            cmd.wr_class = 1'b1;
            cmd.wr_val   = CL_REJECT;
          end
          if ({1'b0, q_r} != probe_r) begin
            emit.en       = 1'b1;
            emit.res.kind = K_REJECT;
            emit.res.dest = q_r;
          end else begin
            state_nxt = S_DT;
          end
        end
      end
      S_ACC: begin
        probe_nxt = NIL_ID;
        if (sts.rd_w < best_w_r) begin
          best_w_nxt  = sts.rd_w;
          best_id_nxt = {1'b0, q_r};
        end
        state_nxt = S_DR;
      end
      S_REJ: begin
        if (sts.rd_class == CL_BASIC) begin
          cmd.wr_class = 1'b1;
          cmd.wr_val   = CL_REJECT;
        end
        state_nxt = S_DT;
      end
      S_DT: begin
        cmd.start = 1'b1;
        cmd.op    = SC_MIN;
        state_nxt = S_DT_W;
      end
      S_DT_W: begin
        if (sts.done) begin
          if (sts.min_found) begin
            probe_nxt     = {1'b0, sts.min_id};
            emit.en       = 1'b1;
            emit.res.kind = K_TEST;
            emit.res.dest = sts.min_id;
            emit.res.lvl  = level_r;
            emit.res.val  = name_r;
            state_nxt     = S_END;
          end else begin
            probe_nxt = NIL_ID;
            state_nxt = S_DR;
          end
        end
      end
      S_DR: begin
        cmd.start = 1'b1;
        cmd.op    = SC_CNT;
        cmd.key   = {1'b0, parent_r};
        state_nxt = S_DR_W;
      end
      S_DR_W: begin
        if (sts.done) begin
          if (({2'b00, reports_r} == sts.count) && (probe_r == NIL_ID)) begin
            phase_nxt     = PH_FOUND;
            emit.en       = 1'b1;
            emit.res.kind = K_REPORT;
            emit.res.dest = parent_r;
            emit.res.val  = best_w_r;
          end
          state_nxt = S_END;
        end
      end
      S_REP: begin
        state_nxt = S_END;
        if (q_r != parent_r) begin
          if (v_r < best_w_r) begin
            best_w_nxt  = v_r;
            best_id_nxt = {1'b0, q_r};
          end
          if (reports_r != RPT_MAX) begin
            reports_nxt = reports_r + 1'b1;
          end
          state_nxt = S_DR;
        end else if (phase_r == PH_FIND) begin
          fcmd.push    = 1'b1;
          fcmd.ent.k   = D_REP;
          fcmd.ent.src = q_r;
          fcmd.ent.val = v_r;
        end else if (v_r > best_w_r) begin
          op_nxt    = M_CHROOT;
          state_nxt = S_CR0;
        end else if ((v_r == best_w_r) && (best_w_r == INF_W)) begin
          cmd.start = 1'b1;
          cmd.op    = SC_LIST;
          state_nxt = S_LIST_W;
        end
      end
      S_LIST_W: begin
        if (sts.hit) begin
          emit.en       = 1'b1;
          emit.res.dest = sts.hit_id;
          if (op_r == M_INIT) begin
            emit.res.kind = K_INITIATE;
            emit.res.lvl  = l_r;
            emit.res.val  = v_r;
            emit.res.find = f_r;
          end else begin
            emit.res.kind = K_TERM;
          end
        end
        if (sts.done) begin
          if (op_r == M_INIT) begin
            if (f_r) begin
              reports_nxt = '0;
              state_nxt   = S_DT;
            end else begin
              state_nxt = S_END;
            end
          end else begin
            halted_nxt    = 1'b1;
            emit.en       = 1'b1;
            emit.res.kind = K_HALT;
            state_nxt     = S_END;
          end
        end
      end
      S_CR: begin
        emit.en       = 1'b1;
        emit.res.dest = best_id_r[5:0];
        if (sts.rd_class == CL_BRANCH) begin
          emit.res.kind = K_CHROOT;
        end else begin
          cmd.wr_class  = 1'b1;
          cmd.wr_val    = CL_BRANCH;
          emit.res.kind = K_CONNECT;
          emit.res.lvl  = level_r;
        end
        state_nxt = S_END;
      end
      S_READ: begin
        emit.en       = 1'b1;
        emit.res.kind = K_READ;
        if (sts.found) begin
          emit.res.dest = sts.rd_id;
          emit.res.val  = sts.rd_w;
          emit.res.ek   = sts.rd_class;
          emit.res.ev   = 1'b1;
        end
        state_nxt = S_END;
      end
      S_END: begin
        state_nxt = (!retry_r && !halted_r) ? S_POP : S_FLUSH;
      end
      S_POP: begin
        if (fifo_empty) begin
          state_nxt = S_FLUSH;
        end else begin
          fcmd.pop  = 1'b1;
          state_nxt = S_RDISP;
        end
      end
      S_RDISP: begin
        retry_nxt = 1'b1;
        q_nxt     = rd_ent.src;
        l_nxt     = rd_ent.lvl;
        v_nxt     = rd_ent.val;
        case (rd_ent.k)
          D_CONN:  op_nxt = M_CONN;
          D_TEST:  op_nxt = M_TEST;
          D_REP:   op_nxt = M_REP;
          default: op_nxt = M_POLL;
        endcase
        state_nxt = S_GO;
      end
      S_FLUSH: begin
        flush     = 1'b1;
        state_nxt = S_FW;
      end
      S_FW: begin
        if (flush_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    q_r  <= q_nxt;
    l_r  <= l_nxt;
    v_r  <= v_nxt;
    f_r  <= f_nxt;
    e_r  <= e_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      retry_r   <= 1'b0;
      level_r   <= '0;
      name_r    <= '0;
      phase_r   <= PH_SLEEP;
      parent_r  <= '0;
      best_id_r <= '0;
      best_w_r  <= '0;
      probe_r   <= '0;
      reports_r <= '0;
      halted_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      retry_r   <= retry_nxt;
      level_r   <= level_nxt;
      name_r    <= name_nxt;
      phase_r   <= phase_nxt;
      parent_r  <= parent_nxt;
      best_id_r <= best_id_nxt;
      best_w_r  <= best_w_nxt;
      probe_r   <= probe_nxt;
      reports_r <= reports_nxt;
      halted_r  <= halted_nxt;
    end
  end

endmodule

[rtl/ghs_mst_node_protocol.sv]
// Top level of one GHS minimum spanning tree node.
//
//   channel   direction  handshake              contents
//   in_*      input      in_valid / in_ready    one item: mode, sender, level, value, find, slot
//   out_*     output     out_valid / out_ready  one message word, out_last on the final one
//
// An item's time goes to the control sequence, its edge table scans and the draining of its result
// words from the result buffer. A message needs up to four scans, and the retried deferred entry
// up to four more. The edge table scanner examines one entry per cycle and takes most of the time.
// An edge load gives no words.
// Reset clears all control and node state; no clearing pass follows it.
// A stalled output holds its word; the next item is taken once the last word is loaded.
module ghs_mst_node_protocol #(
  parameter int MAX_EDGES   = ghs_pkg::MAX_EDGES_DEF,
  parameter int DEFER_DEPTH = ghs_pkg::DEFER_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_mode,
  input  logic [5:0]  in_src_node,
  input  logic [3:0]  in_level,
  input  logic [16:0] in_value,
  input  logic        in_find,
  input  logic [3:0]  in_edge_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_kind,
  output logic [5:0]  out_dest_node,
  output logic [3:0]  out_msg_level,
  output logic [16:0] out_msg_value,
  output logic        out_msg_find,
  output logic [1:0]  out_edge_kind,
  output logic        out_edge_valid,
  output logic        out_defer_overflow,
  output logic        out_last
);
  import ghs_pkg::*;

  localparam int CAP = 2 * MAX_EDGES + 2;

  ghs_cmd_t   cmd;
  ghs_sts_t   sts;
  ghs_fcmd_t  fcmd;
  ghs_defer_t rd_ent;
  ghs_emit_t  emit;
  ghs_res_t   out_res;
  logic       fifo_empty, ovf, flush, flush_done;

  ghs_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_src_node   (in_src_node),
    .in_level      (in_level),
    .in_value      (in_value),
    .in_find       (in_find),
    .in_edge_index (in_edge_index),
    .cmd           (cmd),
    .sts           (sts),
    .fcmd          (fcmd),
    .rd_ent        (rd_ent),
    .fifo_empty    (fifo_empty),
    .emit          (emit),
    .flush         (flush),
    .flush_done    (flush_done)
  );

  ghs_etab #(.MAX_EDGES(MAX_EDGES)) u_etab (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .sts   (sts)
  );

  ghs_dfifo #(.DEFER_DEPTH(DEFER_DEPTH)) u_dfifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .fcmd   (fcmd),
    .rd_ent (rd_ent),
    .empty  (fifo_empty),
    .ovf    (ovf)
  );

  ghs_obuf #(.CAP(CAP)) u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit      (emit),
    .flush     (flush),
    .ovf       (ovf),
    .done      (flush_done),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res),
    .out_last  (out_last),
    .out_ovf   (out_defer_overflow)
  );

  assign out_kind       = out_res.kind;
  assign out_dest_node  = out_res.dest;
  assign out_msg_level  = out_res.lvl;
  assign out_msg_value  = out_res.val;
  assign out_msg_find   = out_res.find;
  assign out_edge_kind  = out_res.ek;
  assign out_edge_valid = out_res.ev;

endmodule

[rtl/ghs_chk.sv]
// Port-level checker for the GHS node, bound to the top level.
`include "assert_macros.svh"

module ghs_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_kind,
  input logic [5:0]  out_dest_node,
  input logic [16:0] out_msg_value,
  input logic [1:0]  out_edge_kind,
  input logic        out_edge_valid,
  input logic        out_defer_overflow,
  input logic        out_last
);
  import ghs_pkg::*;

  `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable({out_kind, out_dest_node, out_msg_value, out_last}))
  `ASSERT_IMP(a_readout_only, clk, rst_n, out_valid && (out_kind != K_READ), !out_edge_valid && (out_edge_kind == CL_BASIC))
  `ASSERT_IMP(a_halt_final, clk, rst_n, out_valid && (out_kind == K_HALT), out_last && (out_dest_node == 6'd0))
  `ASSERT_NXT(a_ovf_sticky, clk, rst_n, out_valid && out_defer_overflow, !out_valid || out_defer_overflow)

endmodule

bind ghs_mst_node_protocol ghs_chk u_chk (.*);

[tb/ghs_node_checker.sv]
// Checker for the GHS node: predicts the outgoing message words and compares them.
`timescale 1ns / 100ps
module ghs_node_checker
  import ghs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [3:0]  in_mode,
  input  logic [5:0]  in_src_node,
  input  logic [3:0]  in_level,
  input  logic [16:0] in_value,
  input  logic        in_find,
  input  logic [3:0]  in_edge_index,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  out_kind,
  input  logic [5:0]  out_dest_node,
  input  logic [3:0]  out_msg_level,
  input  logic [16:0] out_msg_value,
  input  logic        out_msg_find,
  input  logic [1:0]  out_edge_kind,
  input  logic        out_edge_valid,
  input  logic        out_defer_overflow,
  input  logic        out_last,
  output int          errors,
  output int          pending,
  output int          words_seen
);

  localparam int NEDGE = 16;
  localparam int NDEFER = 32;
  localparam int WORD_CAP = 34;

  typedef struct packed {
    ghs_res_t r;
    logic     ovf;
    logic     lst;
  } msg_word_t;

  msg_word_t  expected_words[$];
  ghs_res_t   step_words[$];

  logic [5:0]  nid [NEDGE];
  logic [16:0] nwt [NEDGE];
  logic [1:0]  ncl [NEDGE];
  int          total;
  logic [3:0]  flvl;
  logic [16:0] fname;
  logic [1:0]  phase;
  logic [5:0]  parent;
  logic [6:0]  best;
  logic [16:0] bestw;
  logic [6:0]  probe;
  logic [4:0]  nrep;
  logic        halted;
  logic        ovf;
  ghs_defer_t  dq [NDEFER];
  int          dhead;
  int          dfill;

  function automatic void put(logic [3:0] k, logic [5:0] d, logic [3:0] l, logic [16:0] v,
                              logic f, logic [1:0] ek, logic ev);
    ghs_res_t r;
    if (step_words.size() >= WORD_CAP) return;
    r.kind = k; r.dest = d; r.lvl = l; r.val = v; r.find = f; r.ek = ek; r.ev = ev;
    step_words.insert(step_words.size(), r);
  endfunction

  function automatic int lookup(logic [6:0] id);
    for (int i = 0; i < total; i++)
      if ({1'b0, nid[i]} == id) return i;
    return -1;
  endfunction

  function automatic int lightest();
    int b;
    b = -1;
    for (int i = 0; i < total; i++)
      if (ncl[i] == CL_BASIC && (b < 0 || nwt[i] < nwt[b])) b = i;
    return b;
  endfunction

  function automatic void defer(logic [1:0] k, logic [5:0] s, logic [3:0] l, logic [16:0] v);
    ghs_defer_t e;
    if (dfill >= NDEFER) begin
      ovf = 1'b1;
      return;
    end
    e.k = k; e.src = s; e.lvl = l; e.val = v;
    dq[(dhead + dfill) % NDEFER] = e;
    dfill++;
  endfunction

  function automatic void wake_up();
    int idx;
    if (phase != PH_SLEEP) return;
    idx = lightest();
    if (idx < 0) return;
    ncl[idx] = CL_BRANCH;
    flvl = 0;
    phase = PH_FOUND;
    nrep = 0;
    put(K_CONNECT, nid[idx], 0, 0, 0, 0, 0);
  endfunction

  function automatic void report_up();
    int n;
    n = 0;
    for (int i = 0; i < total; i++)
      if (ncl[i] == CL_BRANCH && nid[i] != parent) n++;
    if (nrep == n && probe == NIL_ID) begin
      phase = PH_FOUND;
      put(K_REPORT, parent, 0, bestw, 0, 0, 0);
    end
  endfunction

  function automatic void probe_next();
    int idx;
    idx = lightest();
    if (idx >= 0) begin
      probe = {1'b0, nid[idx]};
      put(K_TEST, nid[idx], flvl, fname, 0, 0, 0);
    end else begin
      probe = NIL_ID;
      report_up();
    end
  endfunction

  function automatic void reroot();
    int idx;
    if (best == NIL_ID) return;
    idx = lookup(best);
    if (idx < 0) return;
    if (ncl[idx] == CL_BRANCH) begin
      put(K_CHROOT, best[5:0], 0, 0, 0, 0, 0);
    end else begin
      ncl[idx] = CL_BRANCH;
      put(K_CONNECT, best[5:0], flvl, 0, 0, 0, 0);
    end
  endfunction

  function automatic void halt_all(logic [5:0] exc, logic use_exc);
    for (int i = 0; i < total; i++)
      if (ncl[i] == CL_BRANCH && !(use_exc && nid[i] == exc))
        put(K_TERM, nid[i], 0, 0, 0, 0, 0);
    halted = 1'b1;
    put(K_HALT, 0, 0, 0, 0, 0, 0);
  endfunction

  function automatic void got_connect(logic [5:0] q, logic [3:0] l);
    int idx;
    idx = lookup({1'b0, q});
    if (idx < 0) return;
    wake_up();
    if (l < flvl) begin
      ncl[idx] = CL_BRANCH;
      put(K_INITIATE, q, flvl, fname, phase == PH_FIND, 0, 0);
    end else if (ncl[idx] == CL_BASIC) begin
      defer(D_CONN, q, l, 0);
    end else begin
      put(K_INITIATE, q, (flvl < LVL_MAX) ? flvl + 4'd1 : LVL_MAX, nwt[idx], 1, 0, 0);
    end
  endfunction

  function automatic void got_initiate(logic [3:0] l, logic [16:0] nm, logic f, logic [5:0] q);
    flvl = l;
    fname = nm;
    phase = f ? PH_FIND : PH_FOUND;
    parent = q;
    best = NIL_ID;
    bestw = INF_W;
    for (int i = 0; i < total; i++)
      if (ncl[i] == CL_BRANCH && nid[i] != q) put(K_INITIATE, nid[i], l, nm, f, 0, 0);
    if (phase == PH_FIND) begin
      nrep = 0;
      probe_next();
    end
  endfunction

  function automatic void got_test(logic [3:0] l, logic [16:0] nm, logic [5:0] q);
    int idx;
    idx = lookup({1'b0, q});
    if (idx < 0) return;
    wake_up();
    if (l > flvl) begin
      defer(D_TEST, q, l, nm);
    end else if (nm != fname) begin
      put(K_ACCEPT, q, 0, 0, 0, 0, 0);
    end else begin
      if (ncl[idx] == CL_BASIC) ncl[idx] = CL_REJECT;
      if ({1'b0, q} != probe) put(K_REJECT, q, 0, 0, 0, 0, 0);
      else probe_next();
    end
  endfunction

  function automatic void got_accept(logic [5:0] q);
    int idx;
    idx = lookup({1'b0, q});
    if (idx < 0) return;
    probe = NIL_ID;
    if (nwt[idx] < bestw) begin
      bestw = nwt[idx];
      best = {1'b0, q};
    end
    report_up();
  endfunction

  function automatic void got_reject(logic [5:0] q);
    int idx;
    idx = lookup({1'b0, q});
    if (idx < 0) return;
    if (ncl[idx] == CL_BASIC) ncl[idx] = CL_REJECT;
    probe_next();
  endfunction

  function automatic void got_report(logic [16:0] w, logic [5:0] q);
    if (q != parent) begin
      if (w < bestw) begin
        bestw = w;
        best = {1'b0, q};
      end
      if (nrep < RPT_MAX) nrep++;
      report_up();
    end else if (phase == PH_FIND) begin
      defer(D_REP, q, 0, w);
    end else if (w > bestw) begin
      reroot();
    end else if (w == bestw && bestw == INF_W) begin
      halt_all(0, 1'b0);
    end
  endfunction

  function automatic void retry_one();
    ghs_defer_t e;
    if (dfill == 0) return;
    e = dq[dhead];
    dhead = (dhead + 1) % NDEFER;
    dfill--;
    if (e.k == D_CONN) got_connect(e.src, e.lvl);
    else if (e.k == D_TEST) got_test(e.lvl, e.val, e.src);
    else if (e.k == D_REP) got_report(e.val, e.src);
  endfunction

  function automatic void predict_words(logic [3:0] m, logic [5:0] s, logic [3:0] l,
                                        logic [16:0] v, logic f, logic [3:0] slot);
    msg_word_t w;
    step_words.delete();
    if (m == M_LOAD) begin
      if (v != INF_W && total < NEDGE) begin
        nid[total] = s;
        nwt[total] = v;
        ncl[total] = CL_BASIC;
        total++;
      end
      return;
    end
    if (m == M_READ) begin
      if (slot < total) put(K_READ, nid[slot], 0, nwt[slot], 0, ncl[slot], 1);
      else put(K_READ, 0, 0, 0, 0, 0, 0);
    end else if (!halted) begin
      case (m)
        M_WAKE:   wake_up();
        M_CONN:   got_connect(s, l);
        M_INIT:   got_initiate(l, v, f, s);
        M_TEST:   got_test(l, v, s);
        M_ACC:    got_accept(s);
        M_REJ:    got_reject(s);
        M_REP:    got_report(v, s);
        M_CHROOT: reroot();
        M_TERM:   halt_all(s, 1'b1);
        default:  ;
      endcase
    end
    if (!halted) retry_one();
    for (int k = 0; k < step_words.size(); k++) begin
      w.r = step_words[k];
      w.ovf = ovf;
      w.lst = (k == step_words.size() - 1);
      expected_words.insert(expected_words.size(), w);
    end
  endfunction

  function automatic void chk(string name, int unsigned e, int unsigned a);
    if (e != a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    msg_word_t w;
    if (!rst_n) begin
      for (int i = 0; i < NEDGE; i++) begin
        nid[i] = 0; nwt[i] = 0; ncl[i] = CL_BASIC;
      end
      total = 0; flvl = 0; fname = 0; phase = PH_SLEEP; parent = 0; best = 0;
      bestw = 0; probe = 0; nrep = 0; halted = 0; ovf = 0; dhead = 0; dfill = 0;
      expected_words.delete();
      errors = 0;
      words_seen = 0;
    end else begin
      if (in_valid && in_ready)
        predict_words(in_mode, in_src_node, in_level, in_value, in_find, in_edge_index);
      if (out_valid && out_ready) begin
        words_seen++;
        if (expected_words.size() == 0) begin
          $error("word of kind %0d arrived with none expected", out_kind);
          errors++;
        end else begin
          w = expected_words.pop_front();
          chk("kind", w.r.kind, out_kind);
          chk("dest_node", w.r.dest, out_dest_node);
          chk("msg_level", w.r.lvl, out_msg_level);
          chk("msg_value", w.r.val, out_msg_value);
          chk("msg_find", w.r.find, out_msg_find);
          chk("edge_kind", w.r.ek, out_edge_kind);
          chk("edge_valid", w.r.ev, out_edge_valid);
          chk("defer_overflow", w.ovf, out_defer_overflow);
          chk("last", w.lst, out_last);
        end
      end
    end
    pending = expected_words.size();
  end

endmodule

[tb/ghs_mst_node_protocol_tb.sv]
// Testbench top for the GHS node: reset, stimulus, flow control and verdict.
`timescale 1ns / 100ps
module ghs_mst_node_protocol_tb;
  import ghs_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [3:0]  in_mode;
  logic [5:0]  in_src_node;
  logic [3:0]  in_level;
  logic [16:0] in_value;
  logic        in_find;
  logic [3:0]  in_edge_index;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  out_kind;
  logic [5:0]  out_dest_node;
  logic [3:0]  out_msg_level;
  logic [16:0] out_msg_value;
  logic        out_msg_find;
  logic [1:0]  out_edge_kind;
  logic        out_edge_valid;
  logic        out_defer_overflow;
  logic        out_last;

  int          errors;
  int          pending;
  int          words_seen;
  int          items_sent;
  int          idle_pct;
  int          stall_pct;
  logic        hold_go;
  logic        hold_done;
  int          hold_cnt;
  logic [5:0]  nbrs[$];

  ghs_mst_node_protocol u_top (.*);

  ghs_node_checker u_chk (.*);

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_cnt <= 0;
      hold_done <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_cnt <= 400;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic offer(logic [3:0] m, logic [5:0] s, logic [3:0] l, logic [16:0] v,
                       logic f, logic [3:0] slot);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= m;
    in_src_node <= s;
    in_level <= l;
    in_value <= v;
    in_find <= f;
    in_edge_index <= slot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic load_edge(logic [5:0] id, logic [16:0] w);
    offer(M_LOAD, id, 4'($urandom_range(15)), w, 1'($urandom_range(1)),
          4'($urandom_range(15)));
    if (w != INF_W && nbrs.size() < 16) nbrs.insert(nbrs.size(), id);
  endtask

  function automatic logic [5:0] pick_src();
    if (nbrs.size() > 0 && $urandom_range(99) < 85)
      return nbrs[$urandom_range(nbrs.size() - 1)];
    return 6'($urandom_range(63));
  endfunction

  task automatic random_item();
    int r;
    logic [3:0] m;
    logic [3:0] l;
    logic [16:0] v;
    r = $urandom_range(99);
    l = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(2));
    v = ($urandom_range(3) == 0) ? 17'($urandom_range(131071)) : 17'($urandom_range(3));
    if (r < 8) begin
      case ($urandom_range(9))
        0:       v = INF_W;
        1:       v = 17'($urandom_range(131071, 100001));
        default: v = 17'($urandom_range(2000));
      endcase
      load_edge(6'($urandom_range(63)), v);
      return;
    end
    if (r < 20) m = M_CONN;
    else if (r < 32) m = M_INIT;
    else if (r < 50) m = M_TEST;
    else if (r < 62) m = M_ACC;
    else if (r < 72) m = M_REJ;
    else if (r < 84) m = M_REP;
    else if (r < 88) m = M_CHROOT;
    else if (r < 90) m = M_WAKE;
    else if (r < 93) m = M_POLL;
    else if (r < 98) m = M_READ;
    else m = M_READ + 4'($urandom_range(4, 1));
    if (m == M_REP)
      v = ($urandom_range(7) == 0) ? 17'($urandom_range(131071, 100001)) :
                                     17'($urandom_range(99999));
    offer(m, pick_src(), l, v, 1'($urandom_range(1)), 4'($urandom_range(15)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  initial begin
    logic [5:0] p;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_mode <= M_POLL;
    in_src_node <= 0;
    in_level <= 0;
    in_value <= 0;
    in_find <= 0;
    in_edge_index <= 0;
    hold_go <= 1'b0;
    items_sent = 0;
    idle_pct = 0;
    stall_pct = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer(M_READ, 0, 0, 0, 0, 0);
    offer(M_WAKE, 0, 0, 0, 0, 0);
    offer(M_POLL, 0, 0, 0, 0, 0);
    load_edge(3, INF_W);
    load_edge(3, 40);
    load_edge(17, 40);
    load_edge(63, 0);
    load_edge(0, 17'd131071);
    load_edge(3, 55);
    offer(M_CONN, 50, 0, 0, 0, 0);
    offer(M_TEST, 17, 0, 0, 0, 0);
    offer(M_INIT, 63, 15, 17'd131071, 1, 0);
    offer(M_REP, 0, 0, 12, 0, 0);
    offer(M_ACC, 17, 0, 0, 0, 0);
    offer(M_REJ, 3, 0, 0, 0, 0);
    offer(M_CHROOT, 0, 0, 0, 0, 0);
    offer(M_TEST, 63, 15, 17'd131071, 0, 0);
    offer(M_CONN, 0, 15, 0, 0, 0);
    offer(M_READ + 4'd4, 0, 0, 0, 0, 0);
    offer(M_READ, 0, 0, 0, 0, 15);
    offer(M_READ, 0, 0, 0, 0, 2);

    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 68 : (ph == 3) ? 8 : 0;
      stall_pct = (ph == 2) ? 68 : (ph == 3) ? 8 : 0;
      if (ph == 1) hold_go <= 1'b1;
      for (int i = 0; i < 45; i++) random_item();
    end

    idle_pct = 0;
    stall_pct = 0;
    p = nbrs[0];
    offer(M_INIT, p, 0, 5, 0, 0);
    repeat (40) offer(M_TEST, p, 15, 9, 0, 0);
    offer(M_READ, 0, 0, 0, 0, 1);

    if ($urandom_range(1)) begin
      offer(M_INIT, p, 0, 7, 0, 0);
      offer(M_REP, p, 0, INF_W, 0, 0);
    end else begin
      offer(M_TERM, p, 0, 0, 0, 0);
    end
    offer(M_POLL, 0, 0, 0, 0, 0);
    offer(M_TERM, p, 0, 0, 0, 0);
    offer(M_WAKE, 0, 0, 0, 0, 0);
    load_edge(9, 33);
    offer(M_READ, 0, 0, 0, 0, 0);

    drain();
    repeat (300) @(posedge clk);
    $display("Sent %0d input words and checked %0d message words", items_sent, words_seen);
    $display("across four idle and stall mixes, a long output hold and a FIFO overflow.");
    if (errors == 0 && pending == 0) begin
      $display("ghs_mst_node_protocol_tb: PASS");
    end else begin
      $display("ghs_mst_node_protocol_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("ghs_mst_node_protocol_tb: FAIL");
    $finish;
  end

endmodule
